// ===== design/lig_pkg.sv =====
// shared types, constants, the weight table and saturating count functions for the ligand statistics block
`default_nettype none

package lig_pkg;

    localparam int MAX_FRAMES  = 32;
    localparam int COUNT_BITS  = 10;
    localparam int FRAME_W     = $clog2(MAX_FRAMES);
    localparam int TOTAL_W     = $clog2(MAX_FRAMES + 1);
    localparam int OUT_W       = 10;
    localparam int OUT_MAX     = (1 << OUT_W) - 1;
    localparam int SHOW_W      = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;
    localparam int COORD_W     = 24;
    localparam int WEIGHT_W    = 28;
    localparam int WENTRY_W    = 18;
    localparam int TYPE_W      = 5;
    localparam int KIND_W      = 2;
    localparam int AXIS_W      = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_ATOM   = 2'd0,
        KIND_OPEN   = 2'd1,
        KIND_CLOSE  = 2'd2,
        KIND_FINISH = 2'd3
    } kind_t;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    localparam logic [TYPE_W-1:0] TYPE_H           = 5'd0;
    localparam logic [TYPE_W-1:0] TYPE_HD          = 5'd1;
    localparam logic [TYPE_W-1:0] TYPE_NA          = 5'd5;
    localparam logic [TYPE_W-1:0] TYPE_OA          = 5'd6;
    localparam logic [TYPE_W-1:0] TYPE_METAL_LO    = 5'd15;
    localparam logic [TYPE_W-1:0] TYPE_METAL_HI    = 5'd30;
    localparam logic [TYPE_W-1:0] TYPE_UNSUPPORTED = 5'd31;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [COUNT_BITS-1:0]     count_t;
    typedef logic [OUT_W-1:0]          show_t;

    // atomic weight in milli mass units, last slot unused
    localparam logic [WENTRY_W-1:0] WEIGHT_TABLE [32] = '{
        18'd1008,   18'd1008,   18'd12010,  18'd12010,  18'd14010,  18'd14010,
        18'd16000,  18'd32070,  18'd32070,  18'd78960,  18'd30970,  18'd19000,
        18'd35450,  18'd79900,  18'd126900, 18'd65380,  18'd55850,  18'd24310,
        18'd40080,  18'd54940,  18'd63550,  18'd22990,  18'd39100,  18'd200590,
        18'd58690,  18'd58930,  18'd112410, 18'd74920,  18'd87620,  18'd238030,
        18'd132910, 18'd0
    };

    typedef struct packed {
        kind_t                 kind;
        logic                  is_hydrogen;
        logic                  is_donor;
        logic                  is_acceptor;
        logic                  is_heavy;
        logic [WENTRY_W-1:0]   weight;
        coord_t                x;
        coord_t                y;
        coord_t                z;
    } op_t;

    typedef struct packed {
        logic [AXIS_W-1:0]   axis;
        logic                last;
        show_t               hydrogens;
        show_t               heavy_atoms;
        show_t               donors;
        show_t               acceptors;
        show_t               active_torsions;
        show_t               inactive_torsions;
        logic [WEIGHT_W-1:0] weight;
        coord_t              low_bound;
        coord_t              high_bound;
        logic                overflow;
    } result_t;

    function automatic count_t bump(input count_t c);
        return (c == '1) ? c : count_t'(c + 1'b1);
    endfunction

    function automatic show_t show_count(input count_t c);
        logic [SHOW_W-1:0] wide;
        wide = SHOW_W'(c);
        if (wide > SHOW_W'(OUT_MAX))
            return '1;
        else
            return wide[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/ligand_statistics_accumulator.sv =====
// top level of the ligand statistics accumulator
// input channel: in_valid/in_ready carry one record item per beat (kind, atom_type,
//   pos_x, pos_y, pos_z); atom fields matter only for kind atom, type 31 is dropped
// output channel: out_valid/out_ready carry one result item per axis, three per
//   finish record, axis 0..2 in order, last set on the z item
// throughput: one record item per cycle while the queue has room; the back end retires
//   every non-finish record at the queue head and holds a finish until its z item is loaded
// result path: a finish item passes through the queue, then the back end loads its
//   result items into the result register one per cycle while out_ready is high
// the front end classifies items and feeds a four-entry queue; in_ready drops only
//   when that queue is full, so input keeps flowing while a result waits
// receiver stall: the result register holds its item and the back end stops at the
//   finish record; queued records wait and the input stalls once the queue fills
// reset: counts, weight and overflow clear, bounds go to their extreme values, the
//   frame store holds only the root frame; no clearing pass is needed
// after the z result of a finish is loaded, all statistics return to reset values
`default_nettype none

module ligand_statistics_accumulator
    import lig_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [KIND_W-1:0]   kind,
    input  wire logic [TYPE_W-1:0]   atom_type,
    input  wire coord_t              pos_x,
    input  wire coord_t              pos_y,
    input  wire coord_t              pos_z,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [AXIS_W-1:0]        axis,
    output logic                     last,
    output show_t                    hydrogens,
    output show_t                    heavy_atoms,
    output show_t                    donors,
    output show_t                    acceptors,
    output show_t                    active_torsions,
    output show_t                    inactive_torsions,
    output logic [WEIGHT_W-1:0]      weight,
    output coord_t                   low_bound,
    output coord_t                   high_bound,
    output logic                     overflow
);

    // front to queue
    logic    push_valid;
    logic    push_ready;
    op_t     push_op;

    // queue to back
    logic    head_valid;
    logic    head_pop;
    op_t     head_op;

    result_t result;

    lig_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .atom_type  (atom_type),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    lig_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (head_valid),
        .pop        (head_pop),
        .pop_op     (head_op)
    );

    lig_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (head_valid),
        .op_pop     (head_pop),
        .op         (head_op),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result)
    );

    // break the result register out onto its field ports
    assign axis              = result.axis;
    assign last              = result.last;
    assign hydrogens         = result.hydrogens;
    assign heavy_atoms       = result.heavy_atoms;
    assign donors            = result.donors;
    assign acceptors         = result.acceptors;
    assign active_torsions   = result.active_torsions;
    assign inactive_torsions = result.inactive_torsions;
    assign weight            = result.weight;
    assign low_bound         = result.low_bound;
    assign high_bound        = result.high_bound;
    assign overflow          = result.overflow;

    // the closing item of a report always describes the z axis
    a_last_is_z: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (axis == AXIS_Z))
        else $error("last result not on z axis");

    // any counted atom leaves a nonzero weight and a proper box
    a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (weight != '0)) |-> (low_bound <= high_bound))
        else $error("bounding box inverted with atoms present");

    // zero weight means no atom was ever counted
    a_empty_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (weight == '0)) |-> ((hydrogens == '0) && (heavy_atoms == '0)))
        else $error("atoms counted without weight");

    // the front only stalls when the queue has no room
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_ready) |-> (head_valid && !push_ready))
        else $error("input stalled with room in the queue");

endmodule

`default_nettype wire

// ===== design/lig_front.sv =====
// front end: accepts records, drops unsupported atoms, classifies the rest
`default_nettype none

module lig_front
    import lig_pkg::*;
(
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [KIND_W-1:0]   kind,
    input  wire logic [TYPE_W-1:0]   atom_type,
    input  wire coord_t              pos_x,
    input  wire coord_t              pos_y,
    input  wire coord_t              pos_z,
    output logic                     push_valid,
    input  wire logic                push_ready,
    output op_t                      push_op
);

    kind_t k;
    logic  skip;

    always_comb
    begin
        k    = kind_t'(kind);
        skip = (k == KIND_ATOM) && (atom_type == TYPE_UNSUPPORTED);

        push_op             = '0;
        push_op.kind        = k;
        push_op.x           = pos_x;
        push_op.y           = pos_y;
        push_op.z           = pos_z;
        push_op.weight      = WEIGHT_TABLE[atom_type];
        push_op.is_hydrogen = (atom_type == TYPE_H) || (atom_type == TYPE_HD);
        push_op.is_heavy    = !push_op.is_hydrogen;
        push_op.is_donor    = (atom_type == TYPE_HD) ||
                              (atom_type inside {[TYPE_METAL_LO:TYPE_METAL_HI]});
        push_op.is_acceptor = atom_type inside {TYPE_NA, TYPE_OA};
    end

    // skipped atoms are taken and dropped without touching the queue
    assign in_ready   = push_ready;
    assign push_valid = in_valid && !skip;

endmodule

`default_nettype wire

// ===== design/lig_queue.sv =====
// short fifo of classified records between front and back
`default_nettype none

module lig_queue
    import lig_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire op_t  push_op,
    output logic      pop_valid,
    input  wire logic pop,
    output op_t       pop_op
);

    op_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = QCNT_W'(count_reg + 1'b1);
        else if (do_pop && !do_push)
            count_next = QCNT_W'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_op;
    end

endmodule

`default_nettype wire

// ===== design/lig_back.sv =====
// back end: counters, weight, bounds, frame store and result register
`default_nettype none

module lig_back
    import lig_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic op_valid,
    output logic      op_pop,
    input  wire op_t  op,
    output logic      out_valid,
    input  wire logic out_ready,
    output result_t   result
);

    count_t              hyd_reg, hyd_next;
    count_t              heavy_reg, heavy_next;
    count_t              donor_reg, donor_next;
    count_t              accept_reg, accept_next;
    count_t              active_reg, active_next;
    count_t              inactive_reg, inactive_next;
    logic [WEIGHT_W-1:0] weight_reg, weight_next;
    coord_t              min_reg [3];
    coord_t              min_next [3];
    coord_t              max_reg [3];
    coord_t              max_next [3];
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [FRAME_W-1:0]  cur_reg, cur_next;
    logic                ovf_reg, ovf_next;
    logic [AXIS_W-1:0]   axis_reg, axis_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    // frame store, entry zero is the root and is never written
    logic [FRAME_W-1:0]  parent_mem [MAX_FRAMES];
    count_t              rotor_mem [MAX_FRAMES];

    logic                slot_free, is_finish, emit, clear;
    logic                open_ok, inactive_hit;
    logic [FRAME_W-1:0]  parent_rd;
    count_t              rotor_rd;
    logic [WEIGHT_W:0]   wsum;
    coord_t              pos [3];

    assign slot_free = !out_valid_reg || out_ready;
    assign is_finish = (op.kind == KIND_FINISH);
    assign emit      = op_valid && is_finish && slot_free;
    assign clear     = emit && (axis_reg == AXIS_Z);
    assign op_pop    = op_valid && (!is_finish || clear);
    assign open_ok   = (total_reg < TOTAL_W'(MAX_FRAMES));

    assign parent_rd = (cur_reg == '0) ? '0 : parent_mem[cur_reg];
    assign rotor_rd  = (cur_reg == '0) ? '0 : rotor_mem[cur_reg];
    assign inactive_hit = ((TOTAL_W'(cur_reg) + 1'b1) == total_reg) &&
                          ((COUNT_BITS+1)'(rotor_rd) + 1'b1 == (COUNT_BITS+1)'(heavy_reg));

    always_comb
    begin
        pos[0] = op.x;
        pos[1] = op.y;
        pos[2] = op.z;
        wsum   = (WEIGHT_W+1)'(weight_reg) + (WEIGHT_W+1)'(op.weight);

        hyd_next      = hyd_reg;
        heavy_next    = heavy_reg;
        donor_next    = donor_reg;
        accept_next   = accept_reg;
        active_next   = active_reg;
        inactive_next = inactive_reg;
        weight_next   = weight_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        total_next    = total_reg;
        cur_next      = cur_reg;
        ovf_next      = ovf_reg;
        axis_next     = axis_reg;

        if (op_valid)
        begin
            case (op.kind)
                KIND_ATOM:
                begin
                    if (op.is_hydrogen) hyd_next    = bump(hyd_reg);
                    if (op.is_heavy)    heavy_next  = bump(heavy_reg);
                    if (op.is_donor)    donor_next  = bump(donor_reg);
                    if (op.is_acceptor) accept_next = bump(accept_reg);
                    weight_next = wsum[WEIGHT_W] ? '1 : wsum[WEIGHT_W-1:0];
                    for (int i = 0; i < 3; i++)
                    begin
                        if (pos[i] < min_reg[i]) min_next[i] = pos[i];
                        if (pos[i] > max_reg[i]) max_next[i] = pos[i];
                    end
                end
                KIND_OPEN:
                begin
                    if (open_ok)
                    begin
                        cur_next   = total_reg[FRAME_W-1:0];
                        total_next = TOTAL_W'(total_reg + 1'b1);
                    end
                    else
                        ovf_next = 1'b1;
                end
                KIND_CLOSE:
                begin
                    if (inactive_hit)
                        inactive_next = bump(inactive_reg);
                    else
                        active_next = bump(active_reg);
                    cur_next = parent_rd;
                end
                default:
                begin
                    if (emit)
                        axis_next = clear ? AXIS_X : AXIS_W'(axis_reg + 1'b1);
                    if (clear)
                    begin
                        hyd_next      = '0;
                        heavy_next    = '0;
                        donor_next    = '0;
                        accept_next   = '0;
                        active_next   = '0;
                        inactive_next = '0;
                        weight_next   = '0;
                        for (int i = 0; i < 3; i++)
                        begin
                            min_next[i] = {1'b0, {(COORD_W-1){1'b1}}};
                            max_next[i] = {1'b1, {(COORD_W-1){1'b0}}};
                        end
                        total_next = TOTAL_W'(1);
                        cur_next   = '0;
                        ovf_next   = 1'b0;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next             = 1'b1;
            out_next.axis              = axis_reg;
            out_next.last              = (axis_reg == AXIS_Z);
            out_next.hydrogens         = show_count(hyd_reg);
            out_next.heavy_atoms       = show_count(heavy_reg);
            out_next.donors            = show_count(donor_reg);
            out_next.acceptors         = show_count(accept_reg);
            out_next.active_torsions   = show_count(active_reg);
            out_next.inactive_torsions = show_count(inactive_reg);
            out_next.weight            = weight_reg;
            out_next.low_bound         = min_reg[axis_reg];
            out_next.high_bound        = max_reg[axis_reg];
            out_next.overflow          = ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hyd_reg       <= '0;
            heavy_reg     <= '0;
            donor_reg     <= '0;
            accept_reg    <= '0;
            active_reg    <= '0;
            inactive_reg  <= '0;
            weight_reg    <= '0;
            for (int i = 0; i < 3; i++)
            begin
                min_reg[i] <= {1'b0, {(COORD_W-1){1'b1}}};
                max_reg[i] <= {1'b1, {(COORD_W-1){1'b0}}};
            end
            total_reg     <= TOTAL_W'(1);
            cur_reg       <= '0;
            ovf_reg       <= 1'b0;
            axis_reg      <= AXIS_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hyd_reg       <= hyd_next;
            heavy_reg     <= heavy_next;
            donor_reg     <= donor_next;
            accept_reg    <= accept_next;
            active_reg    <= active_next;
            inactive_reg  <= inactive_next;
            weight_reg    <= weight_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            total_reg     <= total_next;
            cur_reg       <= cur_next;
            ovf_reg       <= ovf_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (op_valid && (op.kind == KIND_OPEN) && open_ok)
        begin
            parent_mem[total_reg[FRAME_W-1:0]] <= cur_reg;
            rotor_mem[total_reg[FRAME_W-1:0]]  <= heavy_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = out_reg;

endmodule

`default_nettype wire

// ===== verif/ligand_stats_checker.sv =====
// channel monitor, result prediction and field comparison for the ligand statistics block
`timescale 1ns / 1ps

module ligand_stats_checker
    import lig_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [KIND_W-1:0]   kind,
    input  logic [TYPE_W-1:0]   atom_type,
    input  coord_t              pos_x,
    input  coord_t              pos_y,
    input  coord_t              pos_z,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [AXIS_W-1:0]   axis,
    input  logic                last,
    input  show_t               hydrogens,
    input  show_t               heavy_atoms,
    input  show_t               donors,
    input  show_t               acceptors,
    input  show_t               active_torsions,
    input  show_t               inactive_torsions,
    input  logic [WEIGHT_W-1:0] weight,
    input  coord_t              low_bound,
    input  coord_t              high_bound,
    input  logic                overflow,
    output int                  error_count,
    output int                  pending_count,
    output int                  result_count
);

    localparam logic [AXIS_W-1:0] AXIS_ORDER [3] = '{AXIS_X, AXIS_Y, AXIS_Z};

    count_t              n_hydrogen;
    count_t              n_heavy;
    count_t              n_donor;
    count_t              n_acceptor;
    count_t              n_active;
    count_t              n_inactive;
    logic [WEIGHT_W-1:0] mass_total;
    coord_t              box_lo [3];
    coord_t              box_hi [3];
    logic [FRAME_W-1:0]  frame_up [MAX_FRAMES];
    count_t              frame_mark [MAX_FRAMES];
    logic [TOTAL_W-1:0]  frames_open;
    logic [FRAME_W-1:0]  frame_now;
    logic                frame_overflow;
    result_t             stats_due [$];

    initial
    begin
        error_count   = 0;
        pending_count = 0;
        result_count  = 0;
    end

    function automatic count_t count_up(input count_t c);
        logic [COUNT_BITS:0] wide;
        wide = {1'b0, c} + 1'b1;
        return wide[COUNT_BITS] ? c : wide[COUNT_BITS-1:0];
    endfunction

    function automatic show_t shown(input count_t c);
        return (int'(c) > OUT_MAX) ? show_t'(OUT_MAX) : show_t'(c);
    endfunction

    // milli mass units per type code
    function automatic int unsigned mass_milli(input logic [TYPE_W-1:0] t);
        case (t)
            5'd0, 5'd1: return 1008;
            5'd2, 5'd3: return 12010;
            5'd4, 5'd5: return 14010;
            5'd6:       return 16000;
            5'd7, 5'd8: return 32070;
            5'd9:       return 78960;
            5'd10:      return 30970;
            5'd11:      return 19000;
            5'd12:      return 35450;
            5'd13:      return 79900;
            5'd14:      return 126900;
            5'd15:      return 65380;
            5'd16:      return 55850;
            5'd17:      return 24310;
            5'd18:      return 40080;
            5'd19:      return 54940;
            5'd20:      return 63550;
            5'd21:      return 22990;
            5'd22:      return 39100;
            5'd23:      return 200590;
            5'd24:      return 58690;
            5'd25:      return 58930;
            5'd26:      return 112410;
            5'd27:      return 74920;
            5'd28:      return 87620;
            5'd29:      return 238030;
            5'd30:      return 132910;
            default:    return 0;
        endcase
    endfunction

    task automatic clear_stats();
        n_hydrogen     = '0;
        n_heavy        = '0;
        n_donor        = '0;
        n_acceptor     = '0;
        n_active       = '0;
        n_inactive     = '0;
        mass_total     = '0;
        for (int a = 0; a < 3; a++)
        begin
            box_lo[a] = {1'b0, {(COORD_W-1){1'b1}}};
            box_hi[a] = {1'b1, {(COORD_W-1){1'b0}}};
        end
        for (int f = 0; f < MAX_FRAMES; f++)
        begin
            frame_up[f]   = '0;
            frame_mark[f] = '0;
        end
        frames_open    = TOTAL_W'(1);
        frame_now      = '0;
        frame_overflow = 1'b0;
    endtask

    task automatic apply_record();
        coord_t              pos [3];
        logic [WEIGHT_W:0]   mass_next;
        logic [FRAME_W-1:0]  cf;
        result_t             r;
        pos[0] = pos_x;
        pos[1] = pos_y;
        pos[2] = pos_z;
        case (kind_t'(kind))
            KIND_ATOM:
            begin
                if (atom_type != TYPE_UNSUPPORTED)
                begin
                    if (atom_type == TYPE_H)
                        n_hydrogen = count_up(n_hydrogen);
                    else if (atom_type == TYPE_HD)
                    begin
                        n_hydrogen = count_up(n_hydrogen);
                        n_donor    = count_up(n_donor);
                    end
                    else
                    begin
                        if (atom_type >= TYPE_METAL_LO)
                            n_donor = count_up(n_donor);
                        if (atom_type == TYPE_NA || atom_type == TYPE_OA)
                            n_acceptor = count_up(n_acceptor);
                        n_heavy = count_up(n_heavy);
                    end
                    mass_next  = {1'b0, mass_total} + (WEIGHT_W+1)'(mass_milli(atom_type));
                    mass_total = mass_next[WEIGHT_W] ? '1 : mass_next[WEIGHT_W-1:0];
                    for (int a = 0; a < 3; a++)
                    begin
                        if (pos[a] < box_lo[a])
                            box_lo[a] = pos[a];
                        if (pos[a] > box_hi[a])
                            box_hi[a] = pos[a];
                    end
                end
            end
            KIND_OPEN:
            begin
                if (int'(frames_open) >= MAX_FRAMES)
                    frame_overflow = 1'b1;
                else
                begin
                    frame_up[frames_open[FRAME_W-1:0]]   = frame_now;
                    frame_mark[frames_open[FRAME_W-1:0]] = n_heavy;
                    frame_now   = frames_open[FRAME_W-1:0];
                    frames_open = frames_open + 1'b1;
                end
            end
            KIND_CLOSE:
            begin
                cf = frame_now;
                // leaf test: newest frame and exactly one heavy atom since it opened
                if (int'(cf) + 1 == int'(frames_open)
                    && int'(frame_mark[cf]) + 1 == int'(n_heavy))
                    n_inactive = count_up(n_inactive);
                else
                    n_active = count_up(n_active);
                frame_now = frame_up[cf];
            end
            KIND_FINISH:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    r.axis              = AXIS_ORDER[k];
                    r.last              = (k == 2);
                    r.hydrogens         = shown(n_hydrogen);
                    r.heavy_atoms       = shown(n_heavy);
                    r.donors            = shown(n_donor);
                    r.acceptors         = shown(n_acceptor);
                    r.active_torsions   = shown(n_active);
                    r.inactive_torsions = shown(n_inactive);
                    r.weight            = mass_total;
                    r.low_bound         = box_lo[k];
                    r.high_bound        = box_hi[k];
                    r.overflow          = frame_overflow;
                    stats_due = {stats_due, r};
                end
                clear_stats();
            end
        endcase
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic check_result();
        result_t want;
        result_count++;
        if (stats_due.size() == 0)
        begin
            error_count++;
            $display("%0t: result item with nothing pending, axis %0d", $time, axis);
        end
        else
        begin
            want = stats_due.pop_front();
            check_field("axis", want.axis, axis);
            check_field("last", want.last, last);
            check_field("hydrogens", want.hydrogens, hydrogens);
            check_field("heavy_atoms", want.heavy_atoms, heavy_atoms);
            check_field("donors", want.donors, donors);
            check_field("acceptors", want.acceptors, acceptors);
            check_field("active_torsions", want.active_torsions, active_torsions);
            check_field("inactive_torsions", want.inactive_torsions, inactive_torsions);
            check_field("weight", want.weight, weight);
            check_field("low_bound", want.low_bound, low_bound);
            check_field("high_bound", want.high_bound, high_bound);
            check_field("overflow", want.overflow, overflow);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_stats();
            stats_due.delete();
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
                apply_record();
        end
        pending_count = stats_due.size();
    end

endmodule

// ===== verif/testbench.sv =====
// top of the ligand statistics testbench: clock, reset, record stimulus and verdict
`timescale 1ns / 1ps

module testbench;
    import lig_pkg::*;

    // type codes used by name in the directed records
    localparam logic [TYPE_W-1:0] TYPE_C        = 5'd2;
    localparam logic [TYPE_W-1:0] TYPE_N        = 5'd4;
    localparam logic [TYPE_W-1:0] TYPE_I        = 5'd14;

    localparam coord_t COORD_TOP    = 24'sh7F_FFFF;
    localparam coord_t COORD_BOTTOM = 24'sh80_0000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [KIND_W-1:0]   kind;
    logic [TYPE_W-1:0]   atom_type;
    coord_t              pos_x;
    coord_t              pos_y;
    coord_t              pos_z;
    logic                out_valid;
    logic                out_ready;
    logic [AXIS_W-1:0]   axis;
    logic                last;
    show_t               hydrogens;
    show_t               heavy_atoms;
    show_t               donors;
    show_t               acceptors;
    show_t               active_torsions;
    show_t               inactive_torsions;
    logic [WEIGHT_W-1:0] weight;
    coord_t              low_bound;
    coord_t              high_bound;
    logic                overflow;

    // checker status
    int errors;
    int pending;
    int results;

    // stimulus bookkeeping
    bit send_gaps;
    bit recv_gaps;
    int hold_request;
    int records_sent;
    int counted_items;
    int molecules;

    ligand_statistics_accumulator u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .kind              (kind),
        .atom_type         (atom_type),
        .pos_x             (pos_x),
        .pos_y             (pos_y),
        .pos_z             (pos_z),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .axis              (axis),
        .last              (last),
        .hydrogens         (hydrogens),
        .heavy_atoms       (heavy_atoms),
        .donors            (donors),
        .acceptors         (acceptors),
        .active_torsions   (active_torsions),
        .inactive_torsions (inactive_torsions),
        .weight            (weight),
        .low_bound         (low_bound),
        .high_bound        (high_bound),
        .overflow          (overflow)
    );

    ligand_stats_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .kind              (kind),
        .atom_type         (atom_type),
        .pos_x             (pos_x),
        .pos_y             (pos_y),
        .pos_z             (pos_z),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .axis              (axis),
        .last              (last),
        .hydrogens         (hydrogens),
        .heavy_atoms       (heavy_atoms),
        .donors            (donors),
        .acceptors         (acceptors),
        .active_torsions   (active_torsions),
        .inactive_torsions (inactive_torsions),
        .weight            (weight),
        .low_bound         (low_bound),
        .high_bound        (high_bound),
        .overflow          (overflow),
        .error_count       (errors),
        .pending_count     (pending),
        .result_count      (results)
    );

    // 4 ns clock
    initial
        clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // coordinates: extremes, a band around zero, or anything
    function automatic coord_t rand_coord();
        int pick;
        pick = $urandom_range(0, 5);
        case (pick)
            0:       return COORD_TOP;
            1:       return COORD_BOTTOM;
            2:       return coord_t'(int'($urandom_range(0, 2000)) - 1000);
            default: return coord_t'($urandom);
        endcase
    endfunction

    // mostly supported types, now and then the skipped one
    function automatic logic [TYPE_W-1:0] rand_type();
        if ($urandom_range(0, 11) == 0)
            return TYPE_UNSUPPORTED;
        return TYPE_W'($urandom_range(0, 30));
    endfunction

    // one item on the input channel; valid stays high across back-to-back items
    // and is only dropped for a random idle burst
    task automatic send_record(input kind_t k, input logic [TYPE_W-1:0] t,
                               input coord_t x, input coord_t y, input coord_t z);
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        atom_type <= t;
        pos_x     <= x;
        pos_y     <= y;
        pos_z     <= z;
        // accepted at the first rising edge with ready high
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        records_sent++;
        if (k == KIND_FINISH)
            molecules++;
        // skipped atoms are ignored by the block and not counted
        if (!(k == KIND_ATOM && t == TYPE_UNSUPPORTED))
            counted_items++;
    endtask

    task automatic send_atom(input logic [TYPE_W-1:0] t);
        send_record(KIND_ATOM, t, rand_coord(), rand_coord(), rand_coord());
    endtask

    // non-atom records carry junk in the atom fields, which must not matter
    task automatic send_marker(input kind_t k);
        send_record(k, TYPE_W'($urandom_range(0, 31)), rand_coord(), rand_coord(), rand_coord());
    endtask

    // random molecule body; tidy ones keep branches balanced, the others
    // may close at the root and leave branches open at finish
    task automatic random_molecule(input int body, input bit tidy);
        int depth;
        int pick;
        depth = 0;
        for (int i = 0; i < body; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                send_atom(rand_type());
            else if (pick == 6)
            begin
                send_marker(KIND_OPEN);
                depth++;
            end
            else if (pick == 7)
            begin
                // leaf rotor with one heavy atom
                send_marker(KIND_OPEN);
                send_atom(TYPE_W'($urandom_range(2, 30)));
                send_marker(KIND_CLOSE);
            end
            else if (depth > 0 || !tidy)
            begin
                send_marker(KIND_CLOSE);
                if (depth > 0)
                    depth--;
            end
            else
                send_atom(rand_type());
        end
        while (tidy && depth > 0)
        begin
            send_marker(KIND_CLOSE);
            depth--;
        end
        send_marker(KIND_FINISH);
    endtask

    // open more branches than the frame store holds, then close a few
    task automatic deep_nest();
        send_atom(TYPE_C);
        for (int i = 0; i < MAX_FRAMES; i++)
            send_marker(KIND_OPEN);
        send_atom(TYPE_C);
        repeat (3)
            send_marker(KIND_CLOSE);
        send_marker(KIND_FINISH);
    endtask

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            else if (stall_left == 0 && recv_gaps && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 5);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int base;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        kind          = KIND_ATOM;
        atom_type     = TYPE_H;
        pos_x         = '0;
        pos_y         = '0;
        pos_z         = '0;
        send_gaps     = 1'b1;
        recv_gaps     = 1'b1;
        hold_request  = 0;
        records_sent  = 0;
        counted_items = 0;
        molecules     = 0;

        // reset held low, then released at a falling edge
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty molecule: zero counts, bounds at their reset extremes
        send_marker(KIND_FINISH);

        // skipped atom outside the box must not widen it
        send_record(KIND_ATOM, TYPE_UNSUPPORTED, COORD_BOTTOM, COORD_TOP, COORD_BOTTOM);
        send_record(KIND_ATOM, TYPE_C, 24'sd5, -24'sd5, 24'sd0);
        send_marker(KIND_FINISH);

        // every atom class, with the hydrogens placed at the coordinate extremes
        send_record(KIND_ATOM, TYPE_H, COORD_TOP, COORD_BOTTOM, 24'sd0);
        send_record(KIND_ATOM, TYPE_HD, COORD_BOTTOM, COORD_TOP, -24'sd1);
        send_atom(TYPE_NA);
        send_atom(TYPE_OA);
        send_atom(TYPE_METAL_LO);
        send_atom(TYPE_METAL_HI);
        send_atom(TYPE_I);
        // leaf branch, inactive torsion
        send_marker(KIND_OPEN);
        send_atom(TYPE_N);
        send_marker(KIND_CLOSE);
        // nested branch: inner leaf inactive, outer active
        send_marker(KIND_OPEN);
        send_atom(TYPE_C);
        send_marker(KIND_OPEN);
        send_atom(TYPE_C);
        send_marker(KIND_CLOSE);
        send_marker(KIND_CLOSE);
        // close at the root stays at the root
        send_marker(KIND_CLOSE);
        send_marker(KIND_FINISH);

        // random molecules, mostly well formed
        base = counted_items;
        while (counted_items - base < 15)
            random_molecule($urandom_range(1, 14), $urandom_range(0, 4) != 0);

        // long receiver hold-off while records keep coming, so the queue fills
        // and the input stalls behind a pending report
        send_gaps    = 1'b0;
        hold_request = 60;
        repeat (2)
            random_molecule(6, 1'b1);
        send_gaps = 1'b1;

        deep_nest();

        base = counted_items;
        while (counted_items - base < 8)
            random_molecule($urandom_range(1, 14), $urandom_range(0, 4) != 0);

        // closing stretch at full rate on both sides
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        base = counted_items;
        while (counted_items - base < 12)
            random_molecule($urandom_range(1, 14), $urandom_range(0, 4) != 0);
        in_valid <= 1'b0;

        // drain the reports and let the block settle before the verdict
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("run covered %0d records over %0d molecules, %0d result items compared",
                 records_sent, molecules, results);
        $display("included empty, skipped-atom and frame-overflow molecules and a long output stall");
        if (errors == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
